// ===== design/svf_pkg.sv =====
// Shared types, constants and the digit font for the seven-segment value formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package svf_pkg;

  typedef enum logic [1:0] {
    KIND_DEC    = 2'd0,
    KIND_TENTHS = 2'd1,
    KIND_TIME   = 2'd2,
    KIND_ERR    = 2'd3
  } kind_e;

  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] PointBit = 8'h04;
  localparam logic [7:0] SegE     = 8'h4f;
  localparam logic [7:0] SegR     = 8'h05;

  // Largest value shown in decimal, tenths and time modes; error codes stay below ErrLimit.
  localparam logic [14:0] ValueMax = 15'd9999;
  localparam logic [14:0] ErrLimit = 15'd100;

  // Positions above this address the second driver chip.
  localparam logic [3:0] ChipSplit = 4'd8;

  // One formatted item, handed from the formatter to the write sequencer.
  typedef struct packed {
    logic [3:0][7:0] seg;   // seg[0] is the leftmost digit
    logic            chip;
    logic [3:0]      base;
    logic            drop;  // out of range: no writes
  } fmt_t;

  function automatic logic [7:0] svf_font(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'hfa;
      4'd1: s = 8'h50;
      4'd2: s = 8'he9;
      4'd3: s = 8'hf1;
      4'd4: s = 8'h53;
      4'd5: s = 8'hb3;
      4'd6: s = 8'hbb;
      4'd7: s = 8'h70;
      4'd8: s = 8'hfb;
      4'd9: s = 8'hf3;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/svf_format.sv =====
// Combinational formatter: splits the value into decimal digits and builds
// the four segment bytes plus chip select and base register. Uses svf_pkg.
`default_nettype none

module svf_format (
  input  logic [1:0]    kind_i,
  input  logic [3:0]    position_i,
  input  logic [15:0]   value_i,
  output svf_pkg::fmt_t fmt_o
);
  import svf_pkg::*;

  kind_e       kind;
  logic [13:0] v;
  logic        in_range;
  logic        err_ok;
  logic [27:0] p1000, p100, p10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [6:0]  r1;
  logic [9:0]  r2;
  logic [13:0] r3;
  logic [3:0]  d0, d1, d2, d3;
  logic [7:0]  f0, f1, f2, f3;

  assign kind     = kind_e'(kind_i);
  assign v        = value_i[13:0];
  assign in_range = !value_i[15] && (value_i[14:0] <= ValueMax);
  assign err_ok   = !value_i[15] && (value_i[14:0] < ErrLimit);

  // Reciprocal multiplies, exact for 0..9999.
  assign p1000 = {14'd0, v} * 28'd8389;
  assign p100  = {14'd0, v} * 28'd5243;
  assign p10   = {14'd0, v} * 28'd6554;
  assign q1000 = p1000[26:23];
  assign q100  = p100[25:19];
  assign q10   = p10[25:16];

  // Each digit is a quotient minus ten times the next coarser quotient.
  assign r1 = q100 - ({3'd0, q1000} * 7'd10);
  assign r2 = q10 - ({3'd0, q100} * 10'd10);
  assign r3 = v - ({4'd0, q10} * 14'd10);
  assign d0 = q1000;
  assign d1 = r1[3:0];
  assign d2 = r2[3:0];
  assign d3 = r3[3:0];

  assign f0 = svf_font(d0);
  assign f1 = svf_font(d1);
  assign f2 = svf_font(d2);
  assign f3 = svf_font(d3);

  always_comb begin
    fmt_o.chip = (position_i > ChipSplit);
    fmt_o.base = fmt_o.chip ? (position_i - ChipSplit) : position_i;
    fmt_o.drop = (kind != KIND_ERR) && !in_range;
    fmt_o.seg  = '0;
    case (kind)
      KIND_DEC: begin
        fmt_o.seg[0] = (q1000 != '0) ? f0 : SegBlank;
        fmt_o.seg[1] = (q100 != '0) ? f1 : SegBlank;
        fmt_o.seg[2] = (q10 != '0) ? f2 : SegBlank;
        fmt_o.seg[3] = f3;
      end
      KIND_TENTHS: begin
        fmt_o.seg[0] = (q1000 != '0) ? f0 : SegBlank;
        fmt_o.seg[1] = (q100 != '0) ? f1 : SegBlank;
        fmt_o.seg[2] = f2 | PointBit;
        fmt_o.seg[3] = f3;
      end
      KIND_TIME: begin
        fmt_o.seg[0] = f0;
        fmt_o.seg[1] = f1 | PointBit;
        fmt_o.seg[2] = f2;
        fmt_o.seg[3] = f3;
      end
      default: begin
        fmt_o.seg[0] = SegE;
        fmt_o.seg[1] = SegR;
        fmt_o.seg[2] = err_ok ? f2 : SegBlank;
        fmt_o.seg[3] = err_ok ? f3 : SegBlank;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/svf_emit.sv =====
// Result register and write sequencer: holds one formatted item and sends
// its four digit writes, one per cycle while out_ready_i is high. Uses svf_pkg.
`default_nettype none

module svf_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  svf_pkg::fmt_t fmt_i,
  output logic          load_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          second_chip_o,
  output logic [3:0]    digit_address_o,
  output logic [7:0]    segments_o,
  output logic          last_o
);
  import svf_pkg::*;

  logic            busy_q, busy_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [3:0][7:0] seg_q;
  logic            chip_q;
  logic [3:0]      base_q;
  logic            out_fire;

  assign out_fire     = busy_q && out_ready_i;
  assign last_o       = (cnt_q == 2'd3);
  assign load_ready_o = !busy_q || (out_fire && last_o);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (out_fire) begin
      cnt_d = cnt_q + 2'd1;
      if (last_o) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      seg_q  <= fmt_i.seg;
      chip_q <= fmt_i.chip;
      base_q <= fmt_i.base;
    end
  end

  assign out_valid_o     = busy_q;
  assign second_chip_o   = chip_q;
  assign digit_address_o = base_q + {2'd0, cnt_q};
  assign segments_o      = seg_q[cnt_q];

  // A new item only replaces one whose last write goes out this cycle.
  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (out_fire && last_o)))
    else $error("item loaded over undelivered writes");

  // Writes inside an item keep coming and step the register address.
  a_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_o) |=> (out_valid_o &&
      (digit_address_o == 4'($past(digit_address_o) + 4'd1))))
    else $error("digit write sequence broken");

  a_chip_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_o) |=> $stable(second_chip_o))
    else $error("chip select changed inside an item");

endmodule

`default_nettype wire

// ===== design/seven_segment_value_formatter.sv =====
// Top level of the seven-segment value formatter: input register, formatter
// and write sequencer. Depends on svf_pkg, svf_format and svf_emit.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | kind_i, position_i, value_i
//   out     | out_valid_o/out_ready_i | second_chip_o, digit_address_o, segments_o,
//           |                        | last_o
//
// An item waits in the input register, is formatted and loaded into the result
// register, then leaves as four writes, one per cycle while out_ready_i is high.
// The input register takes a new item while writes drain. Out-of-range items are
// dropped in the input register, also under a stall; else a stalled output holds
// everything. Reset clears the valid and count flags only.
`default_nettype none

module seven_segment_value_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  position_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        second_chip_o,
  output logic [3:0]  digit_address_o,
  output logic [7:0]  segments_o,
  output logic        last_o
);
  import svf_pkg::*;

  logic        s1_valid_q;
  logic [1:0]  kind_q;
  logic [3:0]  position_q;
  logic [15:0] value_q;
  fmt_t        fmt;
  logic        load_ready;
  logic        load;
  logic        s1_adv;

  // Dropped items leave without waiting for the result register.
  assign load       = s1_valid_q && !fmt.drop && load_ready;
  assign s1_adv     = s1_valid_q && (fmt.drop || load_ready);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q     <= kind_i;
      position_q <= position_i;
      value_q    <= value_i;
    end
  end

  svf_format u_format (
    .kind_i     (kind_q),
    .position_i (position_q),
    .value_i    (value_q),
    .fmt_o      (fmt)
  );

  svf_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .fmt_i           (fmt),
    .load_ready_o    (load_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .second_chip_o   (second_chip_o),
    .digit_address_o (digit_address_o),
    .segments_o      (segments_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
